[rtl/signed_int_divider_saturating_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed saturating divider
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_DIVIDER_SATURATING_ASSERT_SVH
`define SIGNED_INT_DIVIDER_SATURATING_ASSERT_SVH

// Same-cycle implication.
`define SIDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider check failed in the same cycle");

// Next-cycle implication.
`define SIDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("divider check failed in the next cycle");

`endif

[rtl/sids_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider package
// Command bundle between controller and datapath, and result flag positions.
// ----------------------------------------------------------------------------
package sids_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands and set up the magnitudes
    logic step;    // produce one quotient bit
    logic finish;  // apply sign and saturation into the output register
  } cmd_t;

  // Bit positions of the result flags on the output tuser.
  localparam int USER_OVF_BIT = 0;
  localparam int USER_DZ_BIT  = 1;
  localparam int USER_WIDTH   = 2;

endpackage

[rtl/sids_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider controller
// Sequences load, one step per quotient bit, and the output hand-off.
// ----------------------------------------------------------------------------
module sids_ctrl
  import sids_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(DATA_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          out_valid;
  logic          out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    count_next     = count;
    out_valid_next = out_valid;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (count == LAST_STEP) begin
          state_next = ST_DONE;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ST_DONE: begin
        // The output register is reloaded only once its previous transfer is done.
        if (!out_valid || m_tready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

endmodule

[rtl/sids_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider datapath
// Restoring shift-subtract on magnitudes, then sign and saturation.
// ----------------------------------------------------------------------------
module sids_datapath
  import sids_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  cmd_t                         cmd,
  input  logic signed [DATA_WIDTH-1:0] numerator,
  input  logic signed [DATA_WIDTH-1:0] denominator,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         overflow_flag,
  output logic                         zero_divisor_flag
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] quo;       // dividend bits shift out, quotient bits shift in
  logic [W-1:0] rem;
  logic [W-1:0] div;
  logic         neg_result;
  logic         div_zero;
  logic [W+1:0] trial;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;
  logic [W-1:0] result;
  logic         result_ovf;

  // The magnitude of the most negative value is still exact as unsigned.
  assign num_mag = numerator[W-1]   ? (W'(0) - numerator)   : numerator;
  assign den_mag = denominator[W-1] ? (W'(0) - denominator) : denominator;

  // Remainder stays below the divisor, so the shifted value fits in W+1 bits.
  assign trial = {1'b0, rem, quo[W-1]} - {2'b00, div};

  always_comb begin
    result_ovf = 1'b0;
    if (div_zero) begin
      result = '0;
    end else if (neg_result) begin
      result = W'(0) - quo;
    end else if (quo[W-1]) begin
      result     = Q_MAX;
      result_ovf = 1'b1;
    end else begin
      result = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo        <= num_mag;
      rem        <= '0;
      div        <= den_mag;
      neg_result <= numerator[W-1] ^ denominator[W-1];
      div_zero   <= (denominator == '0);
    end else if (cmd.step) begin
      if (!trial[W+1]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      quotient          <= result;
      overflow_flag     <= result_ovf;
      zero_divisor_flag <= div_zero;
    end
  end

endmodule

[rtl/signed_int_divider_saturating.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer divider, truncating and saturating
// Top level: stream ports around the controller and the datapath.
// ----------------------------------------------------------------------------
// Divides a signed dividend by a signed divisor and rounds toward zero. A zero
// divisor returns 0 with the zero-divisor flag set; the most negative value
// divided by minus one returns the largest positive value with the overflow
// flag set. One item is in work at a time: the operands are taken, the
// shift-subtract unit works out one quotient bit per cycle, and then sign
// and saturation are applied into the output register. That register holds
// a finished result while the next item is taken and worked on.
module signed_int_divider_saturating
  import sids_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // numerator [DATA_WIDTH-1:0], denominator above it, zero padding to bytes
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // quotient [DATA_WIDTH-1:0], zero padding to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
  // overflow_flag [0], zero_divisor_flag [1]
  output logic [USER_WIDTH-1:0]                m_tuser
);

  localparam int W = DATA_WIDTH;

  cmd_t                cmd;
  logic signed [W-1:0] quotient;
  logic                overflow_flag;
  logic                zero_divisor_flag;

  sids_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  sids_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .numerator         (s_tdata[W-1:0]),
    .denominator       (s_tdata[2*W-1:W]),
    .quotient          (quotient),
    .overflow_flag     (overflow_flag),
    .zero_divisor_flag (zero_divisor_flag)
  );

  always_comb begin
    m_tdata        = '0;
    m_tdata[W-1:0] = quotient;
    m_tuser                = '0;
    m_tuser[USER_OVF_BIT]  = overflow_flag;
    m_tuser[USER_DZ_BIT]   = zero_divisor_flag;
  end

endmodule

[rtl/sids_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed divider port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "signed_int_divider_saturating_assert.svh"

module sids_checker
  import sids_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
  input logic [USER_WIDTH-1:0]             m_tuser
);

  localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // A saturated result and a zero-divisor result never come together.
  `SIDS_ASSERT_NOW(flags_exclusive, m_tvalid, !(m_tuser[USER_OVF_BIT] && m_tuser[USER_DZ_BIT]))
  `SIDS_ASSERT_NOW(dz_gives_zero, m_tvalid && m_tuser[USER_DZ_BIT], m_tdata[DATA_WIDTH-1:0] == '0)
  `SIDS_ASSERT_NOW(ovf_gives_max, m_tvalid && m_tuser[USER_OVF_BIT], m_tdata[DATA_WIDTH-1:0] == Q_MAX)
  // Only one item is in work, so input is closed right after a transfer.
  `SIDS_ASSERT_NEXT(busy_after_take, s_tvalid && s_tready, !s_tready)
  `SIDS_ASSERT_NEXT(result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind signed_int_divider_saturating sids_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sids_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[verif/signed_int_divider_saturating_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed saturating divider testbench
// Drives operand pairs into the divider over the input stream with random
// gaps and output back-pressure. Each accepted transfer is paired with a
// quotient predicted here, and every output transfer is compared with it.
// ----------------------------------------------------------------------------
module signed_int_divider_saturating_tb
  import sids_pkg::*;
();

  localparam int DW = 32;
  localparam logic [DW-1:0] MOST_NEG  = 32'h8000_0000;
  localparam logic [DW-1:0] MOST_POS  = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] MINUS_ONE = 32'hFFFF_FFFF;
  localparam int IDLE_PCT = 18;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [DW-1:0] quot;
    logic          ovf;
    logic          dz;
  } div_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [2*DW-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DW-1:0]       m_tdata;
  logic [USER_WIDTH-1:0] m_tuser;

  div_result_t quot_q[$];
  int          err_cnt = 0;
  int          hold_cycles = 0;
  bit          calm = 1'b0;

  signed_int_divider_saturating #(.DATA_WIDTH(DW)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Truncating division on magnitudes, then sign and saturation.
  function automatic div_result_t predict_quotient(input logic [DW-1:0] num,
                                                   input logic [DW-1:0] den);
    div_result_t r;
    logic [DW-1:0] n_mag;
    logic [DW-1:0] d_mag;
    logic [DW-1:0] q_mag;
    r = '0;
    n_mag = num[DW-1] ? (32'd0 - num) : num;
    d_mag = den[DW-1] ? (32'd0 - den) : den;
    if (d_mag == '0) begin
      r.dz = 1'b1;
    end else begin
      q_mag = n_mag / d_mag;
      if (num[DW-1] != den[DW-1]) begin
        r.quot = 32'd0 - q_mag;
      end else if (q_mag > MOST_POS) begin
        r.quot = MOST_POS;
        r.ovf = 1'b1;
      end else begin
        r.quot = q_mag;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Receiver: random stalls, a calm mode, and a counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    div_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (quot_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: quotient %h flags %b",
                                m_tdata, m_tuser));
      end else begin
        want = quot_q.pop_front();
        if (m_tdata !== want.quot)
          flag_mismatch($sformatf("quotient: expected %h, got %h", want.quot, m_tdata));
        if (m_tuser[USER_OVF_BIT] !== want.ovf)
          flag_mismatch($sformatf("overflow flag: expected %b, got %b (quotient %h)",
                                  want.ovf, m_tuser[USER_OVF_BIT], want.quot));
        if (m_tuser[USER_DZ_BIT] !== want.dz)
          flag_mismatch($sformatf("zero divisor flag: expected %b, got %b (quotient %h)",
                                  want.dz, m_tuser[USER_DZ_BIT], want.quot));
      end
    end
  end

  // Valid stays high from one transfer to the next unless a gap is taken.
  task automatic send_div(input logic [DW-1:0] num, input logic [DW-1:0] den);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {den, num};
    do @(posedge clk); while (!s_tready);
    quot_q.push_back(predict_quotient(num, den));
  endtask

  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (quot_q.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic test_directed();
    logic [DW-1:0] pairs[$];
    pairs = '{32'd0, 32'd1,        32'd1, 32'd0,        32'd0, 32'd0,
              MOST_NEG, MINUS_ONE,  MOST_NEG, 32'd1,     MOST_NEG, MOST_NEG,
              MOST_POS, MOST_NEG,   MOST_NEG, MOST_POS,  MOST_POS, MINUS_ONE,
              MOST_POS, 32'd1,      MINUS_ONE, 32'd0,    MOST_NEG, 32'd0,
              MOST_POS, 32'd0,      32'd7, 32'd2,        -32'sd7, 32'd2,
              32'd7, -32'sd2,       -32'sd7, -32'sd2,    MOST_NEG, 32'd2,
              MOST_NEG, -32'sd2,    MINUS_ONE, MOST_NEG, 32'd5, 32'd7,
              -32'sd5, 32'd7,       MOST_POS, MOST_POS,  MINUS_ONE, MINUS_ONE};
    for (int i = 0; i < pairs.size(); i += 2) send_div(pairs[i], pairs[i+1]);
  endtask

  task automatic pick_operands(output logic [DW-1:0] num, output logic [DW-1:0] den);
    logic [DW-1:0] q;
    num = $urandom();
    den = $urandom();
    case ($urandom_range(9))
      4: den = $urandom_range(32) - 16;
      5: den = '0;
      6: begin
        num = MOST_NEG;
        case ($urandom_range(3))
          0, 1: den = MINUS_ONE;
          2:    den = $urandom_range(1) ? 32'd1 : -32'sd2;
          default: ;
        endcase
      end
      7: begin
        // Exact multiples exercise a zero remainder.
        den = $urandom() >> $urandom_range(31);
        if ($urandom_range(1)) den = 32'd0 - den;
        if (den == '0) den = 32'd3;
        q = $urandom() >> $urandom_range(31);
        num = q * den;
      end
      8: begin
        num = $urandom() >> $urandom_range(31, 16);
        if ($urandom_range(1)) num = 32'd0 - num;
      end
      9: begin
        num = 32'd1 << $urandom_range(31);
        den = 32'd1 << $urandom_range(31);
        if ($urandom_range(1)) num = 32'd0 - num;
        if ($urandom_range(1)) den = 32'd0 - den;
      end
      default: ;
    endcase
  endtask

  task automatic test_random();
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 150 && i < 210);
      pick_operands(num, den);
      send_div(num, den);
    end
    calm = 1'b0;
  endtask

  // Output held off long enough that the block fills and stops taking input.
  task automatic test_backpressure();
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    calm = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      pick_operands(num, den);
      send_div(num, den);
    end
    calm = 1'b0;
  endtask

  task automatic test_drain_pause();
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    wait_drained(20000);
    for (int i = 0; i < 8; i++) begin
      pick_operands(num, den);
      send_div(num, den);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_backpressure();
    test_random();
    wait_drained(20000);
    repeat (80) @(posedge clk);
    err_cnt += quot_q.size();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
